FILE: rtl/core/pfc_pkg.sv
// pfc_pkg: shared types, codes and letter/cell helpers for the playfair digraph cipher
// depends on nothing; used by the channel interfaces, pfc_square, the top level and the checker
`default_nettype none

package pfc_pkg;

   typedef logic [2:0] op_type;
   typedef logic [4:0] letter_type;
   typedef logic [1:0] status_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] pos_type;

   // request op codes
   localparam op_type OP_CLEAR   = 3'd0;
   localparam op_type OP_KEY     = 3'd1;
   localparam op_type OP_FINISH  = 3'd2;
   localparam op_type OP_ENCRYPT = 3'd3;
   localparam op_type OP_DECRYPT = 3'd4;

   // response status codes
   localparam status_type ST_OK          = 2'd0;
   localparam status_type ST_NOT_READY   = 2'd1;
   localparam status_type ST_KEY_IGNORED = 2'd2;

   localparam cell_type   CELLS    = 5'd25;
   localparam letter_type LETTERS  = 5'd26;
   localparam letter_type LETTER_Z = 5'd25;
   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam pos_type    POS_LAST = 3'd4;

   // write port of the square: cell gets letter, letter gets cell
   typedef struct packed {
      logic       en;
      cell_type   addr;
      letter_type letter;
   } wr_type;

   // read addresses: letters for position lookup, cells for letter lookup
   typedef struct packed {
      letter_type letter_a;
      letter_type letter_b;
      cell_type   cell_a;
      cell_type   cell_b;
   } rd_type;

   // registered read data
   typedef struct packed {
      cell_type   cell_a;
      cell_type   cell_b;
      letter_type letter_a;
      letter_type letter_b;
   } rdata_type;

   // saturate to z, fold j onto i
   function automatic letter_type pair_letter(input letter_type raw);
      letter_type v;
      v = (raw > LETTER_Z) ? LETTER_Z : raw;
      if (v == LETTER_J) begin
         v = LETTER_I;
      end
      return v;
   endfunction

   function automatic pos_type cell_row(input cell_type idx);
      pos_type row;
      if (idx >= 5'd20) begin
         row = 3'd4;
      end else if (idx >= 5'd15) begin
         row = 3'd3;
      end else if (idx >= 5'd10) begin
         row = 3'd2;
      end else if (idx >= 5'd5) begin
         row = 3'd1;
      end else begin
         row = 3'd0;
      end
      return row;
   endfunction

   function automatic cell_type row_base(input pos_type row);
      return {row, 2'b00} + {2'b00, row};
   endfunction

   function automatic pos_type cell_col(input cell_type idx);
      cell_type diff;
      diff = idx - row_base(cell_row(idx));
      return diff[2:0];
   endfunction

   // one step around a row or column, forward or back
   function automatic pos_type step_pos(input pos_type pos, input logic fwd);
      pos_type res;
      if (fwd) begin
         res = (pos == POS_LAST) ? 3'd0 : pos + 3'd1;
      end else begin
         res = (pos == 3'd0) ? POS_LAST : pos - 3'd1;
      end
      return res;
   endfunction

   function automatic cell_type make_cell(input pos_type row, input pos_type col);
      return row_base(row) + {2'b00, col};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pfc_req_if.sv
// pfc_req_if: request channel of the cipher, valid/ready with op and two letters
// depends on pfc_pkg
`default_nettype none

interface pfc_req_if;
   logic                 valid;
   logic                 ready;
   pfc_pkg::op_type      op;
   pfc_pkg::letter_type  letter_a;
   pfc_pkg::letter_type  letter_b;

   modport source (output valid, output op, output letter_a, output letter_b, input ready);
   modport sink   (input valid, input op, input letter_a, input letter_b, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pfc_rsp_if.sv
// pfc_rsp_if: response channel of the cipher, valid/ready with two letters and status
// depends on pfc_pkg
`default_nettype none

interface pfc_rsp_if;
   logic                 valid;
   logic                 ready;
   pfc_pkg::letter_type  out_a;
   pfc_pkg::letter_type  out_b;
   pfc_pkg::status_type  status;

   modport source (output valid, output out_a, output out_b, output status, input ready);
   modport sink   (input valid, input out_a, input out_b, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/playfair_digraph_cipher_top.sv
// playfair_digraph_cipher_top: key schedule and digraph cipher over a 5x5 square
// depends on pfc_pkg, pfc_req_if, pfc_rsp_if and pfc_square
//
//   channel  dir  handshake      payload
//   req_bus  in   valid/ready    op, letter_a, letter_b
//   rsp_bus  out  valid/ready    out_a, out_b, status
//
// one request at a time under a small sequencer; req_bus.ready is high in idle only
// clear and key letter pass through exec and result; encrypt/decrypt add two registered memory
// reads (letter to cell, then cell to letter), finish walks the alphabet (one letter per cycle)
// the response register lets a new request in while a response waits; the
// sequencer only stalls in its result step until that register is free
// reset is synchronous: square empty and not ready, no response pending
`default_nettype none

module playfair_digraph_cipher_top (
   input wire logic  clock,
   input wire logic  reset,
   pfc_req_if.sink   req_bus,
   pfc_rsp_if.source rsp_bus
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_WALK   = 3'd2;
   localparam logic [2:0] S_LOOK   = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   // control state
   logic [2:0]          state_ff, state_in;
   logic [25:0]         used_ff, used_in;
   pfc_pkg::cell_type   fill_ff, fill_in;
   logic                ready_ff, ready_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload
   pfc_pkg::op_type     op_ff, op_in;
   pfc_pkg::letter_type a_ff, a_in;
   pfc_pkg::letter_type b_ff, b_in;
   pfc_pkg::letter_type walk_ff, walk_in;
   pfc_pkg::letter_type res_a_ff, res_a_in;
   pfc_pkg::letter_type res_b_ff, res_b_in;
   pfc_pkg::status_type res_st_ff, res_st_in;
   pfc_pkg::letter_type out_a_ff, out_a_in;
   pfc_pkg::letter_type out_b_ff, out_b_in;
   pfc_pkg::status_type out_st_ff, out_st_in;

   pfc_pkg::wr_type     wr;
   pfc_pkg::rd_type     rd;
   pfc_pkg::rdata_type  rdata;

   // padded so any 5 bit letter indexes it
   logic [31:0]         used_pad;
   logic [31:0]         key_set;
   logic [31:0]         walk_set;

   // position unit
   pfc_pkg::pos_type    row_a, col_a, row_b, col_b;
   pfc_pkg::cell_type   new_a, new_b;
   logic                fwd;

   pfc_square u_square (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .rdata (rdata)
   );

   assign used_pad = {6'b0, used_ff};
   assign key_set  = 32'b1 << a_ff;
   assign walk_set = 32'b1 << walk_ff;

   assign row_a = pfc_pkg::cell_row(rdata.cell_a);
   assign col_a = pfc_pkg::cell_col(rdata.cell_a);
   assign row_b = pfc_pkg::cell_row(rdata.cell_b);
   assign col_b = pfc_pkg::cell_col(rdata.cell_b);
   assign fwd   = (op_ff == pfc_pkg::OP_ENCRYPT);

   // playfair rules: same row, same column, else swap columns
   // a doubled letter lands in the same row case
   always_comb begin
      if (row_a == row_b) begin
         new_a = pfc_pkg::make_cell(row_a, pfc_pkg::step_pos(col_a, fwd));
         new_b = pfc_pkg::make_cell(row_b, pfc_pkg::step_pos(col_b, fwd));
      end else if (col_a == col_b) begin
         new_a = pfc_pkg::make_cell(pfc_pkg::step_pos(row_a, fwd), col_a);
         new_b = pfc_pkg::make_cell(pfc_pkg::step_pos(row_b, fwd), col_b);
      end else begin
         new_a = pfc_pkg::make_cell(row_a, col_b);
         new_b = pfc_pkg::make_cell(row_b, col_a);
      end
   end

   // read addresses are driven every cycle; the sequencer picks the data up when due
   assign rd.letter_a = pfc_pkg::pair_letter(a_ff);
   assign rd.letter_b = pfc_pkg::pair_letter(b_ff);
   assign rd.cell_a   = new_a;
   assign rd.cell_b   = new_b;

   assign req_bus.ready  = (state_ff == S_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.out_a  = out_a_ff;
   assign rsp_bus.out_b  = out_b_ff;
   assign rsp_bus.status = out_st_ff;

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      fill_in      = fill_ff;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      walk_in      = walk_ff;
      res_a_in     = res_a_ff;
      res_b_in     = res_b_ff;
      res_st_in    = res_st_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      out_st_in    = out_st_ff;
      wr.en        = 1'b0;
      wr.addr      = fill_ff;
      wr.letter    = a_ff;

      // response taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.op;
               a_in     = req_bus.letter_a;
               b_in     = req_bus.letter_b;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_a_in  = '0;
            res_b_in  = '0;
            res_st_in = pfc_pkg::ST_OK;
            state_in  = S_RESULT;
            unique case (op_ff) inside
               pfc_pkg::OP_CLEAR: begin
                  used_in  = '0;
                  fill_in  = '0;
                  ready_in = 1'b0;
               end
               pfc_pkg::OP_KEY: begin
                  if (ready_ff || fill_ff >= pfc_pkg::CELLS) begin
                     res_st_in = pfc_pkg::ST_KEY_IGNORED;
                  end else if (a_ff < pfc_pkg::LETTERS && a_ff != pfc_pkg::LETTER_J &&
                               !used_pad[a_ff]) begin
                     wr.en   = 1'b1;
                     used_in = used_ff | key_set[25:0];
                     fill_in = fill_ff + 5'd1;
                  end
               end
               pfc_pkg::OP_FINISH: begin
                  if (!ready_ff) begin
                     walk_in  = '0;
                     state_in = S_WALK;
                  end
               end
               pfc_pkg::OP_ENCRYPT, pfc_pkg::OP_DECRYPT: begin
                  if (!ready_ff) begin
                     res_st_in = pfc_pkg::ST_NOT_READY;
                  end else begin
                     // cell lookups of both letters issued this cycle
                     state_in = S_LOOK;
                  end
               end
               default: begin
               end
            endcase
         end

         // fill free cells with unused letters in alphabet order
         S_WALK: begin
            wr.letter = walk_ff;
            if (walk_ff != pfc_pkg::LETTER_J && !used_pad[walk_ff] &&
                fill_ff < pfc_pkg::CELLS) begin
               wr.en   = 1'b1;
               used_in = used_ff | walk_set[25:0];
               fill_in = fill_ff + 5'd1;
            end
            walk_in = walk_ff + 5'd1;
            if (walk_ff == pfc_pkg::LETTER_Z) begin
               ready_in = 1'b1;
               state_in = S_RESULT;
            end
         end

         // cells are in, new cells go out as square reads
         S_LOOK: begin
            state_in = S_READ;
         end

         S_READ: begin
            res_a_in = rdata.letter_a;
            res_b_in = rdata.letter_b;
            state_in = S_RESULT;
         end

         S_RESULT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               out_a_in     = res_a_ff;
               out_b_in     = res_b_ff;
               out_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         fill_ff      <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         fill_ff      <= fill_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      walk_ff   <= walk_in;
      res_a_ff  <= res_a_in;
      res_b_ff  <= res_b_in;
      res_st_ff <= res_st_in;
      out_a_ff  <= out_a_in;
      out_b_ff  <= out_b_in;
      out_st_ff <= out_st_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/pfc_square.sv
// pfc_square: the 5x5 square as two memories, cell to letter and letter to cell
// depends on pfc_pkg; one write and two registered reads per memory per cycle
`default_nettype none

module pfc_square (
   input  wire logic                clock,
   input  wire pfc_pkg::wr_type     wr,
   input  wire pfc_pkg::rd_type     rd,
   output      pfc_pkg::rdata_type  rdata
);

   pfc_pkg::letter_type square_mem [25];
   pfc_pkg::cell_type   cell_mem   [26];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         square_mem[wr.addr] <= wr.letter;
         cell_mem[wr.letter] <= wr.addr;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      rdata.cell_a   <= cell_mem[rd.letter_a];
      rdata.cell_b   <= cell_mem[rd.letter_b];
      rdata.letter_a <= square_mem[rd.cell_a];
      rdata.letter_b <= square_mem[rd.cell_b];
   end

endmodule

`default_nettype wire

FILE: rtl/core/pfc_checker.sv
// pfc_checker: port level checks of the cipher and its bind to the top level
// depends on pfc_pkg and playfair_digraph_cipher_top
`default_nettype none

module pfc_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire pfc_pkg::letter_type out_a,
   input wire pfc_pkg::letter_type out_b,
   input wire pfc_pkg::status_type status
);

   // a held response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // one request at a time: busy right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in work");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status == pfc_pkg::ST_OK || status == pfc_pkg::ST_NOT_READY ||
                     status == pfc_pkg::ST_KEY_IGNORED))
      else $error("unknown status code");

   // letters are zero on a failed or ignored request
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != pfc_pkg::ST_OK |-> out_a == '0 && out_b == '0)
      else $error("letters on a failed or ignored request");

endmodule

bind playfair_digraph_cipher_top pfc_checker u_pfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .out_a     (rsp_bus.out_a),
   .out_b     (rsp_bus.out_b),
   .status    (rsp_bus.status)
);

`default_nettype wire
